@@ rtl/i2c_shared_register_merge_defines.svh @@
// Assertion macros for the shared register merge block.
// Every check is clocked on clk and held off while arst_n is low.
`ifndef I2C_SHARED_REGISTER_MERGE_DEFINES_SVH
`define I2C_SHARED_REGISTER_MERGE_DEFINES_SVH

// Check that a property holds at every edge.
`define SRM_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("i2c_srm: check failed");

// Check that a condition leads to a consequence at the next edge.
`define SRM_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c_srm: check on next edge failed");

`endif

@@ rtl/i2c_srm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c_srm_pkg
// Shared types, mode codes and the constant pointer-reduction table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2c_srm_pkg;

	localparam int unsigned MAP_DEPTH = 32;
	localparam int unsigned PTR_W     = $clog2(MAP_DEPTH);
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned CADDR_W   = 5;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef ptr_t [255:0]      mod_tab_t;

	localparam mode_t MODE_BUS_START    = 3'd0;
	localparam mode_t MODE_BUS_WRITE    = 3'd1;
	localparam mode_t MODE_BUS_READ     = 3'd2;
	localparam mode_t MODE_BUS_STOP     = 3'd3;
	localparam mode_t MODE_CPU_UPDATE   = 3'd4;
	localparam mode_t MODE_CPU_FINALIZE = 3'd5;
	localparam mode_t MODE_CPU_WRITE    = 3'd6;
	localparam mode_t MODE_CPU_READ     = 3'd7;

	localparam ptr_t LAST_IDX = ptr_t'(MAP_DEPTH - 1);

	// Byte value reduced modulo the map depth, built by counting.
	function automatic mod_tab_t build_mod_tab();
		mod_tab_t tab;
		int unsigned r;
		r = 0;
		for (int unsigned i = 0; i < 256; i++) begin
			tab[i] = ptr_t'(r);
			r = (r == MAP_DEPTH - 1) ? 0 : r + 1;
		end
		return tab;
	endfunction

	localparam mod_tab_t MOD_TAB = build_mod_tab();

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic exec;
		logic sweep;
		logic clear;
		logic capture;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t op;
		logic  loaded;
		logic  idx_last;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/i2c_shared_register_merge.sv @@
// ----------------------------------------------------------------------------
// i2c_shared_register_merge
// Register map shared by an I2C bus slave and a local CPU, merged via staging.
// Input channel (in_valid/in_stall) carries one command beat: mode, data and
// cpu_address. Output channel (out_valid/out_stall) returns one beat per
// command: read_data, the byte for a bus or cpu read and zero otherwise.
// Start, write and cpu write go from execute straight to the result; reads
// capture the stored byte first. The first bus write after a start (refresh),
// bus stop, cpu update and cpu finalize sweep every store entry once, one
// entry per cycle through the single read port of each RAM; no new beat is
// taken until the result is loaded into the output register.
// After reset a clearing pass writes zero to all five stores, with in_stall
// high throughout. A new beat is taken while an earlier result waits in the
// output register; if the receiver stalls, the next result holds inside the
// block until the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_shared_register_merge_defines.svh"

module i2c_shared_register_merge (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [i2c_srm_pkg::MODE_W-1:0]   mode,
	input  wire logic [i2c_srm_pkg::BYTE_W-1:0]   data,
	input  wire logic [i2c_srm_pkg::CADDR_W-1:0]  cpu_address,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [i2c_srm_pkg::BYTE_W-1:0]   read_data
);

	import i2c_srm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer: owns the handshakes and the phase of each command.
	i2c_srm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stores, pointer and result path; acts only on sequencer commands.
	i2c_srm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.data       (data),
		.cpu_address(cpu_address),
		.read_data  (read_data)
	);

	// Every accepted beat is executed on the very next cycle.
	`SRM_CHECK_NEXT(a_take_then_exec, cmd.take, cmd.exec)
	// Never overwrite a result the receiver has not taken.
	`SRM_CHECK(a_load_when_free, cmd.load_out |-> (!out_valid || !out_stall))
	// Commands other than reads return zero.
	`SRM_CHECK_NEXT(a_zero_for_non_read,
		cmd.load_out && sts.op != MODE_BUS_READ && sts.op != MODE_CPU_READ,
		read_data == '0)
	// A sweep stops after its last entry.
	`SRM_CHECK_NEXT(a_sweep_ends, cmd.sweep && sts.idx_last, !cmd.sweep)

endmodule

`default_nettype wire

@@ rtl/i2c_srm_ram.sv @@
// ----------------------------------------------------------------------------
// i2c_srm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_srm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/i2c_srm_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2c_srm_ctrl
// Sequencer: clearing pass, item intake, execute, sweep and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_srm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire i2c_srm_pkg::sts_t sts,
	output i2c_srm_pkg::cmd_t      cmd
);

	import i2c_srm_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_RDWAIT = 3'd3;
	localparam logic [2:0] S_SWEEP  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       need_sweep;
	logic       need_read;

	assign need_sweep = (sts.op == MODE_BUS_WRITE && !sts.loaded) ||
		sts.op == MODE_BUS_STOP || sts.op == MODE_CPU_UPDATE ||
		sts.op == MODE_CPU_FINALIZE;
	assign need_read = sts.op == MODE_BUS_READ || sts.op == MODE_CPU_READ;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				priority if (need_sweep) begin
					state_d = S_SWEEP;
				end else if (need_read) begin
					state_d = S_RDWAIT;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_RDWAIT: begin
				cmd.capture = 1'b1;
				state_d     = S_FINISH;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.idx_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/i2c_srm_datapath.sv @@
// ----------------------------------------------------------------------------
// i2c_srm_datapath
// The five byte stores, byte pointer, sweep index and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_srm_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire i2c_srm_pkg::cmd_t                cmd,
	output i2c_srm_pkg::sts_t                     sts,
	input  wire i2c_srm_pkg::mode_t               mode,
	input  wire logic [i2c_srm_pkg::BYTE_W-1:0]   data,
	input  wire logic [i2c_srm_pkg::CADDR_W-1:0]  cpu_address,
	output logic      [i2c_srm_pkg::BYTE_W-1:0]   read_data
);

	import i2c_srm_pkg::*;

	mode_t op_q;
	byte_t data_q;
	ptr_t  addr_q;
	ptr_t  ptr_q;
	logic  loaded_q;
	ptr_t  idx_q;
	ptr_t  idx_s1;
	logic  wr_s1;
	byte_t result_q;
	byte_t read_data_q;
	ptr_t  ptr_next;

	logic  refresh_bus, merge_bus, refresh_cpu, merge_cpu;

	logic  bc_we, bs_we, st_we, cc_we, cs_we;
	logic  bc_re, bs_re, st_re, cc_re, cs_re;
	ptr_t  bc_wa, bc_ra, sw_wa, cc_wa, cc_ra;
	byte_t bc_wd, bs_wd, st_wd, cc_wd, cs_wd;
	byte_t bc_rd, bs_rd, st_rd, cc_rd, cs_rd;

	assign refresh_bus = op_q == MODE_BUS_WRITE;
	assign merge_bus   = op_q == MODE_BUS_STOP;
	assign refresh_cpu = op_q == MODE_CPU_UPDATE;
	assign merge_cpu   = op_q == MODE_CPU_FINALIZE;
	assign ptr_next    = (ptr_q == LAST_IDX) ? '0 : ptr_q + ptr_t'(1);

	// Sweep-side write address: clearing pass or write stage.
	assign sw_wa = cmd.clear ? idx_q : idx_s1;

	always_comb begin
		// bus working copy
		bc_we = 1'b0;
		bc_wa = ptr_q;
		bc_wd = data_q;
		priority if (cmd.clear) begin
			bc_we = 1'b1;
			bc_wa = idx_q;
			bc_wd = '0;
		end else if (wr_s1 && refresh_bus) begin
			bc_we = 1'b1;
			bc_wa = idx_s1;
			bc_wd = st_rd;
		end else if (cmd.exec && op_q == MODE_BUS_WRITE && loaded_q) begin
			bc_we = 1'b1;
		end
		bc_re = (cmd.exec && op_q == MODE_BUS_READ) || (cmd.sweep && merge_bus);
		bc_ra = cmd.sweep ? idx_q : ptr_q;

		// bus snapshot
		bs_we = cmd.clear || (wr_s1 && (refresh_bus || merge_bus));
		bs_wd = cmd.clear ? '0 : (refresh_bus ? st_rd : bc_rd);
		bs_re = cmd.sweep && merge_bus;

		// staging: written by a merge only where the copy moved off its snapshot
		st_we = cmd.clear || (wr_s1 && merge_bus && bc_rd != bs_rd) ||
			(wr_s1 && merge_cpu && cc_rd != cs_rd);
		st_wd = cmd.clear ? '0 : (merge_bus ? bc_rd : cc_rd);
		st_re = cmd.sweep && (refresh_bus || refresh_cpu);

		// cpu working copy
		cc_we = 1'b0;
		cc_wa = addr_q;
		cc_wd = data_q;
		priority if (cmd.clear) begin
			cc_we = 1'b1;
			cc_wa = idx_q;
			cc_wd = '0;
		end else if (wr_s1 && refresh_cpu) begin
			cc_we = 1'b1;
			cc_wa = idx_s1;
			cc_wd = st_rd;
		end else if (cmd.exec && op_q == MODE_CPU_WRITE) begin
			cc_we = 1'b1;
		end
		cc_re = (cmd.exec && op_q == MODE_CPU_READ) || (cmd.sweep && merge_cpu);
		cc_ra = cmd.sweep ? idx_q : addr_q;

		// cpu snapshot
		cs_we = cmd.clear || (wr_s1 && (refresh_cpu || merge_cpu));
		cs_wd = cmd.clear ? '0 : (refresh_cpu ? st_rd : cc_rd);
		cs_re = cmd.sweep && merge_cpu;
	end

	i2c_srm_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_bus_copy (
		.clk(clk), .we(bc_we), .waddr(bc_wa), .wdata(bc_wd),
		.re(bc_re), .raddr(bc_ra), .rdata(bc_rd)
	);

	i2c_srm_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_bus_snap (
		.clk(clk), .we(bs_we), .waddr(sw_wa), .wdata(bs_wd),
		.re(bs_re), .raddr(idx_q), .rdata(bs_rd)
	);

	i2c_srm_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_staging (
		.clk(clk), .we(st_we), .waddr(sw_wa), .wdata(st_wd),
		.re(st_re), .raddr(idx_q), .rdata(st_rd)
	);

	i2c_srm_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_cpu_copy (
		.clk(clk), .we(cc_we), .waddr(cc_wa), .wdata(cc_wd),
		.re(cc_re), .raddr(cc_ra), .rdata(cc_rd)
	);

	i2c_srm_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_cpu_snap (
		.clk(clk), .we(cs_we), .waddr(sw_wa), .wdata(cs_wd),
		.re(cs_re), .raddr(idx_q), .rdata(cs_rd)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			loaded_q <= 1'b0;
			idx_q    <= '0;
			wr_s1    <= 1'b0;
			op_q     <= MODE_BUS_START;
		end else begin
			wr_s1 <= cmd.sweep;
			if (cmd.take) begin
				op_q <= mode;
			end
			if (cmd.sweep || cmd.clear) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + ptr_t'(1);
			end
			if (cmd.exec) begin
				unique case (op_q)
					MODE_BUS_START: begin
						loaded_q <= 1'b0;
					end
					MODE_BUS_WRITE: begin
						if (!loaded_q) begin
							ptr_q    <= MOD_TAB[data_q];
							loaded_q <= 1'b1;
						end else begin
							ptr_q <= ptr_next;
						end
					end
					MODE_BUS_READ: begin
						ptr_q <= ptr_next;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			data_q <= data;
			addr_q <= MOD_TAB[{{(8 - CADDR_W){1'b0}}, cpu_address}];
		end
		if (cmd.sweep) begin
			idx_s1 <= idx_q;
		end
		if (cmd.exec) begin
			result_q <= '0;
		end else if (cmd.capture) begin
			result_q <= (op_q == MODE_BUS_READ) ? bc_rd : cc_rd;
		end
		if (cmd.load_out) begin
			read_data_q <= result_q;
		end
	end

	assign sts.op       = op_q;
	assign sts.loaded   = loaded_q;
	assign sts.idx_last = idx_q == LAST_IDX;
	assign read_data    = read_data_q;

endmodule

`default_nettype wire
